@@ sv/device_id_name_file_matcher_top_macros.svh @@
// Assertion macros for the device ID name matcher
`ifndef DEVICE_ID_NAME_FILE_MATCHER_TOP_MACROS_SVH
`define DEVICE_ID_NAME_FILE_MATCHER_TOP_MACROS_SVH

// cond must hold at every clock edge outside reset
`define DIM_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante at an edge implies cons at the same edge
`define DIM_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ sv/dim_pkg.sv @@
// Shared types, codes and helpers of the device ID name matcher
package dim_pkg;

	localparam int MAX_ENTRIES_D = 16;
	localparam int NAME_LIMIT_D  = 64;
	localparam int LINE_LIMIT_D  = 256;

	localparam logic [2:0] OP_CLEAR = 3'd0;
	localparam logic [2:0] OP_ADD   = 3'd1;
	localparam logic [2:0] OP_TEXT  = 3'd2;
	localparam logic [2:0] OP_END   = 3'd3;
	localparam logic [2:0] OP_FIND  = 3'd4;

	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_FIND  = 2'd1;
	localparam logic [1:0] KIND_VNAME = 2'd2;
	localparam logic [1:0] KIND_DNAME = 2'd3;

	localparam logic [7:0] CH_NL   = 8'h0A;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_NUL  = 8'h00;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_LINE,
		S_FAIL,
		S_RD,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic tbl_clear;
		logic key_cap;
		logic byte_store;
		logic line_cap;
		logic ans_load;
		logic line_close;
		logic fail_load;
		logic run_read;
		logic run_load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic vendor_emit;
		logic vendor_fail;
		logic device_emit;
		logic run_last;
	} status_t;

	// {valid, value}
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR);
	endfunction

endpackage

@@ sv/dim_if.sv @@
// Input and output channel interfaces of the device ID name matcher
interface dim_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [15:0] vend_key;
	logic [15:0] dev_key;
	logic [7:0]  text_byte;

	modport source (output valid, op, vend_key, dev_key, text_byte, input ready);
	modport sink (input valid, op, vend_key, dev_key, text_byte, output ready);
	modport monitor (input valid, ready, op, vend_key, dev_key, text_byte);
endinterface

interface dim_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic        ok;
	logic [3:0]  entry_index;
	logic [15:0] entry_mask;
	logic [7:0]  name_char;
	logic        last;

	modport source (output valid, kind, ok, entry_index, entry_mask, name_char, last,
		input ready);
	modport sink (input valid, kind, ok, entry_index, entry_mask, name_char, last,
		output ready);
	modport monitor (input valid, ready, kind, ok, entry_index, entry_mask, name_char,
		last);
endinterface

@@ sv/device_id_name_file_matcher_top.sv @@
// Top level of the device ID name matcher
// Usage:
// in_ch carries commands: clear table, add pair, text byte, end of text, find pair.
// out_ch carries answers and name runs (kind, ok, entry_index, entry_mask,
// name_char, last); last marks the final item of a run or a single answer.
// Clear and plain text bytes leave the controller idle and give no result.
// Add and find give one answer each; the table compare over
// all entries is done in parallel and registered before the priority pick.
// A newline or end of text registers the table compares, then S_LINE decides the line;
// a name run then reads each byte from the line RAM (S_RD) and loads it out (S_EMIT).
// A name is at most NAME_LIMIT-1 bytes long.
// in_ch.ready is high only while no command is in progress; an add/find
// answer or a pending output item does not block clears or text bytes.
// When the receiver stalls, the output register holds and the run waits.
// Reset empties the table and the line state; the line RAM and table
// contents are not cleared and need no sweep.
module device_id_name_file_matcher_top import dim_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_D,
	parameter int NAME_LIMIT  = NAME_LIMIT_D,
	parameter int LINE_LIMIT  = LINE_LIMIT_D
) (
	input logic       clk,
	input logic       arst_n,
	dim_in_if.sink    in_ch,
	dim_out_if.source out_ch
);
	`include "device_id_name_file_matcher_top_macros.svh"

	cmd_t    cmd;
	status_t status;
	logic    is_nl;

	assign is_nl = (in_ch.text_byte == CH_NL);

	dim_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.op       (in_ch.op),
		.is_nl    (is_nl),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	dim_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.NAME_LIMIT  (NAME_LIMIT),
		.LINE_LIMIT  (LINE_LIMIT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (in_ch.op),
		.vend_key  (in_ch.vend_key),
		.dev_key   (in_ch.dev_key),
		.text_byte (in_ch.text_byte),
		.cmd       (cmd),
		.status    (status),
		.out_ch    (out_ch)
	);

	`DIM_ASSERT_ALWAYS(a_cmd_onehot, clk, arst_n,
		$onehot0({cmd.tbl_clear, cmd.key_cap, cmd.byte_store, cmd.line_cap, cmd.ans_load,
		cmd.line_close, cmd.fail_load, cmd.run_read, cmd.run_load}),
		"more than one command at once")
	`DIM_ASSERT_IMPLIES(a_load_free, clk, arst_n,
		cmd.ans_load || cmd.fail_load || cmd.run_load, status.out_free,
		"output loaded while occupied")
	`DIM_ASSERT_IMPLIES(a_no_accept_busy, clk, arst_n,
		cmd.run_read || cmd.run_load || cmd.line_close, !in_ch.ready,
		"input accepted during line work")
endmodule

@@ sv/dim_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module dim_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ sv/dim_ctrl.sv @@
// Controller state machine of the device ID name matcher
module dim_ctrl import dim_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [2:0] op,
	input  logic       is_nl,
	output logic       in_ready,
	input  status_t    status,
	output cmd_t       cmd
);
	state_t state_q, state_nx;
	logic   acc;

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (op)
						OP_ADD, OP_FIND: state_nx = S_LOOK;
						OP_TEXT: begin
							if (is_nl) begin
								state_nx = S_LINE;
							end
						end
						OP_END: state_nx = S_LINE;
						default: state_nx = S_IDLE;
					endcase
				end
			end
			S_LOOK: begin
				if (status.out_free) begin
					state_nx = S_IDLE;
				end
			end
			S_LINE: begin
				if (status.vendor_fail) begin
					state_nx = S_FAIL;
				end else if (status.vendor_emit || status.device_emit) begin
					state_nx = S_RD;
				end else begin
					state_nx = S_IDLE;
				end
			end
			S_FAIL: begin
				if (status.out_free) begin
					state_nx = S_IDLE;
				end
			end
			S_RD: state_nx = S_EMIT;
			S_EMIT: begin
				if (status.out_free) begin
					state_nx = status.run_last ? S_IDLE : S_RD;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (op)
						OP_CLEAR: cmd.tbl_clear = 1'b1;
						OP_ADD, OP_FIND: cmd.key_cap = 1'b1;
						OP_TEXT: begin
							if (is_nl) begin
								cmd.line_cap = 1'b1;
							end else begin
								cmd.byte_store = 1'b1;
							end
						end
						OP_END: cmd.line_cap = 1'b1;
						default: cmd = '0;
					endcase
				end
			end
			S_LOOK: cmd.ans_load = status.out_free;
			S_LINE: cmd.line_close = 1'b1;
			S_FAIL: cmd.fail_load = status.out_free;
			S_RD: cmd.run_read = 1'b1;
			S_EMIT: cmd.run_load = status.out_free;
			default: cmd = '0;
		endcase
	end
endmodule

@@ sv/dim_dp.sv @@
// Datapath: ID table, line tracker, line buffer and output register
module dim_dp import dim_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_D,
	parameter int NAME_LIMIT  = NAME_LIMIT_D,
	parameter int LINE_LIMIT  = LINE_LIMIT_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [2:0]  op,
	input  logic [15:0] vend_key,
	input  logic [15:0] dev_key,
	input  logic [7:0]  text_byte,
	input  cmd_t        cmd,
	output status_t     status,
	dim_out_if.source   out_ch
);
	localparam int LW = $clog2(LINE_LIMIT);
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	// entry table
	logic [15:0]            ent_v_q [MAX_ENTRIES];
	logic [15:0]            ent_d_q [MAX_ENTRIES];
	logic [15:0]            key_v_q, key_d_q;
	logic [CW-1:0]          count_q;
	logic [MAX_ENTRIES-1:0] mv_q, vm_q;
	logic                   add_q, end_q;
	logic [IW-1:0]          hidx;
	logic                   hit, full, add_write;

	// line tracker
	logic [LW-1:0] line_len_q, eff_len_q, s_q, e_q;
	logic          ovf_q, zero_q, b0_hash_q, b0_tab_q, b1_tab_q;
	logic [15:0]   hv_q, hd_q;
	logic          hv_ok_q, hd_ok_q, sep4_q, sep5_q, st_found_q;
	logic [15:0]   cur_vendor_q;
	logic          vseen_q;
	logic          room;
	logic [4:0]    hx;
	logic [LW-1:0] sep_pos;

	// line decision
	logic          cond, vendor_ok, device_ok, name_ok, any_v;
	logic [15:0]   mask16;
	logic [3:0]    idx4;

	// run and output
	logic [1:0]    run_kind_q;
	logic [15:0]   run_mask_q;
	logic [3:0]    run_idx_q;
	logic [LW-1:0] ptr_q, last_q;
	logic [7:0]    ram_rdata;
	logic          out_valid_q;
	logic          load;

	assign full = (32'(count_q) >= 32'(MAX_ENTRIES));
	assign room = !ovf_q && (32'(line_len_q) < 32'(LINE_LIMIT - 1));
	assign hx   = hex_nibble(text_byte);
	assign sep_pos = b0_tab_q ? LW'(5) : LW'(4);

	always_comb begin
		hidx = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (mv_q[i]) begin
				hidx = IW'(i);
			end
		end
	end
	assign hit       = |mv_q;
	assign add_write = cmd.ans_load && add_q && !hit && !full;

	always_comb begin
		logic [MAX_ENTRIES+15:0] vext;
		logic [IW+3:0]           iext;
		vext   = {16'b0, vm_q};
		iext   = {4'b0, hidx};
		mask16 = vext[15:0];
		idx4   = iext[3:0];
	end

	assign any_v     = |vm_q;
	assign cond      = !ovf_q && (eff_len_q != '0) && !b0_hash_q;
	assign vendor_ok = cond && !b0_tab_q && (eff_len_q >= LW'(5)) && hv_ok_q && sep4_q
		&& st_found_q;
	assign device_ok = cond && b0_tab_q && !b1_tab_q && vseen_q && (eff_len_q >= LW'(6))
		&& hd_ok_q && sep5_q && st_found_q;
	assign name_ok   = (32'(e_q - s_q) < 32'(NAME_LIMIT - 1));

	assign status.out_free    = !out_valid_q || out_ch.ready;
	assign status.vendor_emit = vendor_ok && any_v && name_ok;
	assign status.vendor_fail = vendor_ok && any_v && !name_ok;
	assign status.device_emit = device_ok && hit && name_ok;
	assign status.run_last    = (ptr_q == last_q);

	// table storage, written from the held key
	always_ff @(posedge clk) begin
		if (add_write) begin
			ent_v_q[count_q[IW-1:0]] <= key_v_q;
			ent_d_q[count_q[IW-1:0]] <= key_d_q;
		end
	end

	// hold the key until the answer is loaded
	always_ff @(posedge clk) begin
		if (cmd.key_cap) begin
			key_v_q <= vend_key;
			key_d_q <= dev_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mv_q    <= '0;
			vm_q    <= '0;
			add_q   <= 1'b0;
			end_q   <= 1'b0;
		end else begin
			if (cmd.tbl_clear) begin
				count_q <= '0;
			end else if (add_write) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.key_cap) begin
				add_q <= (op == OP_ADD);
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					mv_q[i] <= (32'(i) < 32'(count_q)) && (ent_v_q[i] == vend_key)
						&& (ent_d_q[i] == dev_key);
				end
			end else if (cmd.line_cap) begin
				end_q <= (op == OP_END);
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					mv_q[i] <= (32'(i) < 32'(count_q)) && (ent_v_q[i] == cur_vendor_q)
						&& (ent_d_q[i] == hd_q);
					vm_q[i] <= (32'(i) < 32'(count_q)) && (ent_v_q[i] == hv_q);
				end
			end
		end
	end

	// line tracker: parse fields as bytes arrive
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q   <= '0;
			eff_len_q    <= '0;
			ovf_q        <= 1'b0;
			zero_q       <= 1'b0;
			b0_hash_q    <= 1'b0;
			b0_tab_q     <= 1'b0;
			b1_tab_q     <= 1'b0;
			hv_q         <= '0;
			hd_q         <= '0;
			hv_ok_q      <= 1'b1;
			hd_ok_q      <= 1'b1;
			sep4_q       <= 1'b0;
			sep5_q       <= 1'b0;
			st_found_q   <= 1'b0;
			s_q          <= '0;
			e_q          <= '0;
			cur_vendor_q <= '0;
			vseen_q      <= 1'b0;
		end else if (cmd.line_close) begin
			line_len_q <= '0;
			eff_len_q  <= '0;
			ovf_q      <= 1'b0;
			zero_q     <= 1'b0;
			b0_hash_q  <= 1'b0;
			b0_tab_q   <= 1'b0;
			b1_tab_q   <= 1'b0;
			hv_ok_q    <= 1'b1;
			hd_ok_q    <= 1'b1;
			sep4_q     <= 1'b0;
			sep5_q     <= 1'b0;
			st_found_q <= 1'b0;
			if (end_q) begin
				cur_vendor_q <= '0;
				vseen_q      <= 1'b0;
			end else if (vendor_ok) begin
				cur_vendor_q <= hv_q;
				vseen_q      <= 1'b1;
			end
		end else if (cmd.byte_store) begin
			if (!room) begin
				ovf_q <= 1'b1;
			end else begin
				line_len_q <= line_len_q + LW'(1);
				if (!zero_q) begin
					if (text_byte == CH_NUL) begin
						zero_q <= 1'b1;
					end else begin
						eff_len_q <= line_len_q + LW'(1);
						if (line_len_q == LW'(0)) begin
							b0_hash_q <= (text_byte == CH_HASH);
							b0_tab_q  <= (text_byte == CH_TAB);
						end
						if (line_len_q == LW'(1)) begin
							b1_tab_q <= (text_byte == CH_TAB);
						end
						if (line_len_q < LW'(4)) begin
							hv_q    <= {hv_q[11:0], hx[3:0]};
							hv_ok_q <= hv_ok_q && hx[4];
						end
						if (line_len_q >= LW'(1) && line_len_q <= LW'(4)) begin
							hd_q    <= {hd_q[11:0], hx[3:0]};
							hd_ok_q <= hd_ok_q && hx[4];
						end
						if (line_len_q == LW'(4)) begin
							sep4_q <= (text_byte == CH_SP) || (text_byte == CH_TAB);
						end
						if (line_len_q == LW'(5)) begin
							sep5_q <= (text_byte == CH_SP) || (text_byte == CH_TAB);
						end
						if (line_len_q > sep_pos && line_len_q > LW'(3)
							&& !is_blank(text_byte)) begin
							if (!st_found_q) begin
								s_q        <= line_len_q;
								st_found_q <= 1'b1;
							end
							e_q <= line_len_q;
						end
					end
				end
			end
		end
	end

	dim_ram #(
		.WIDTH(8),
		.DEPTH(LINE_LIMIT)
	) u_line_ram (
		.clk   (clk),
		.we    (cmd.byte_store && room),
		.waddr (line_len_q),
		.wdata (text_byte),
		.re    (cmd.run_read),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	// run setup and advance
	always_ff @(posedge clk) begin
		if (cmd.line_close) begin
			run_kind_q <= vendor_ok ? KIND_VNAME : KIND_DNAME;
			run_mask_q <= vendor_ok ? mask16 : 16'd0;
			run_idx_q  <= vendor_ok ? 4'd0 : idx4;
			ptr_q      <= s_q;
			last_q     <= e_q;
		end else if (cmd.run_load) begin
			ptr_q <= ptr_q + LW'(1);
		end
	end

	assign load = cmd.ans_load || cmd.fail_load || cmd.run_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ans_load) begin
			out_ch.kind        <= add_q ? KIND_ADD : KIND_FIND;
			out_ch.ok          <= add_q ? (hit || !full) : hit;
			out_ch.entry_index <= (!add_q && hit) ? idx4 : 4'd0;
			out_ch.entry_mask  <= 16'd0;
			out_ch.name_char   <= 8'd0;
			out_ch.last        <= 1'b1;
		end else if (cmd.fail_load) begin
			out_ch.kind        <= run_kind_q;
			out_ch.ok          <= 1'b0;
			out_ch.entry_index <= 4'd0;
			out_ch.entry_mask  <= run_mask_q;
			out_ch.name_char   <= 8'd0;
			out_ch.last        <= 1'b1;
		end else if (cmd.run_load) begin
			out_ch.kind        <= run_kind_q;
			out_ch.ok          <= 1'b1;
			out_ch.entry_index <= run_idx_q;
			out_ch.entry_mask  <= run_mask_q;
			out_ch.name_char   <= ram_rdata;
			out_ch.last        <= status.run_last;
		end
	end

	assign out_ch.valid = out_valid_q;
endmodule

@@ test/dim_checker.sv @@
// Checker of the device ID name matcher: predicts results and compares them
`timescale 1ns / 1ps
module dim_checker import dim_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	dim_in_if.monitor  mon_in,
	dim_out_if.monitor mon_out,
	output int      fail_count,
	output int      pending
);
	typedef struct packed {
		logic [1:0]  kind;
		logic        ok;
		logic [3:0]  entry_index;
		logic [15:0] entry_mask;
		logic [7:0]  name_char;
		logic        last;
	} answer_t;

	logic [15:0] tbl_vendor [MAX_ENTRIES_D];
	logic [15:0] tbl_device [MAX_ENTRIES_D];
	int          tbl_count;
	logic [7:0]  line_buf [LINE_LIMIT_D];
	int          line_len;
	logic        line_over;
	logic [15:0] cur_vendor;
	logic        vend_known;
	answer_t     answers_due [$];

	function automatic answer_t mk(logic [1:0] k, logic o, logic [3:0] ix, logic [15:0] m,
		logic [7:0] c, logic l);
		answer_t a;
		a.kind = k; a.ok = o; a.entry_index = ix; a.entry_mask = m;
		a.name_char = c; a.last = l;
		return a;
	endfunction

	function automatic int lookup(logic [15:0] v, logic [15:0] d);
		for (int i = 0; i < tbl_count; i++)
			if (tbl_vendor[i] == v && tbl_device[i] == d) return i;
		return -1;
	endfunction

	function automatic logic hex4(int pos, output logic [15:0] val);
		logic [4:0] h;
		val = '0;
		for (int i = 0; i < 4; i++) begin
			h = 5'd0;
			if (line_buf[pos+i] inside {[8'h30:8'h39]}) h = {1'b1, 4'(line_buf[pos+i] - 8'h30)};
			else if (line_buf[pos+i] inside {[8'h61:8'h66]})
				h = {1'b1, 4'(line_buf[pos+i] - 8'h57)};
			else if (line_buf[pos+i] inside {[8'h41:8'h46]})
				h = {1'b1, 4'(line_buf[pos+i] - 8'h37)};
			if (!h[4]) return 1'b0;
			val = {val[11:0], h[3:0]};
		end
		return 1'b1;
	endfunction

	function automatic logic blank(logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_CR;
	endfunction

	// trim [a, b); false when empty or too long
	function automatic logic trim(int a0, int b0, output int a, output int b);
		a = a0; b = b0;
		while (a < b && blank(line_buf[a])) a++;
		while (b > a && blank(line_buf[b-1])) b--;
		return !(b == a || b - a >= NAME_LIMIT_D);
	endfunction

	function automatic void push_name(logic [1:0] k, logic [3:0] ix, logic [15:0] m,
		int a, int b);
		for (int i = a; i < b; i++)
			answers_due.push_back(mk(k, 1'b1, ix, m, line_buf[i], i + 1 == b));
	endfunction

	function automatic void parse_line();
		int n, tabs, pos, a, b, ix;
		logic [15:0] val, m;
		logic any;
		n = 0; tabs = 0; m = '0; any = 1'b0;
		while (n < line_len && line_buf[n] != CH_NUL) n++;
		if (n == 0 || line_buf[0] == CH_HASH) return;
		while (tabs < n && line_buf[tabs] == CH_TAB) tabs++;
		if (tabs == 0) begin
			if (n < 5 || !hex4(0, val)) return;
			if (line_buf[4] != CH_SP && line_buf[4] != CH_TAB) return;
			pos = 4;
			while (pos < n && blank(line_buf[pos])) pos++;
			if (pos >= n) return;
			cur_vendor = val;
			vend_known = 1'b1;
			for (int i = 0; i < tbl_count; i++)
				if (tbl_vendor[i] == val) begin
					any = 1'b1;
					m[i] = 1'b1;
				end
			if (!any) return;
			if (!trim(pos, n, a, b))
				answers_due.push_back(mk(KIND_VNAME, 1'b0, 4'd0, m, 8'd0, 1'b1));
			else push_name(KIND_VNAME, 4'd0, m, a, b);
			return;
		end
		if (tabs != 1 || !vend_known || n < 6) return;
		if (!hex4(1, val)) return;
		if (line_buf[5] != CH_SP && line_buf[5] != CH_TAB) return;
		pos = 5;
		while (pos < n && blank(line_buf[pos])) pos++;
		if (pos >= n) return;
		ix = lookup(cur_vendor, val);
		if (ix < 0 || !trim(pos, n, a, b)) return;
		push_name(KIND_DNAME, 4'(ix), 16'd0, a, b);
	endfunction

	function automatic void predict(logic [2:0] op, logic [15:0] v, logic [15:0] d,
		logic [7:0] c);
		int ix;
		case (op)
			OP_CLEAR: tbl_count = 0;
			OP_ADD: begin
				if (lookup(v, d) >= 0)
					answers_due.push_back(mk(KIND_ADD, 1'b1, 4'd0, 16'd0, 8'd0, 1'b1));
				else if (tbl_count >= MAX_ENTRIES_D)
					answers_due.push_back(mk(KIND_ADD, 1'b0, 4'd0, 16'd0, 8'd0, 1'b1));
				else begin
					tbl_vendor[tbl_count] = v;
					tbl_device[tbl_count] = d;
					tbl_count++;
					answers_due.push_back(mk(KIND_ADD, 1'b1, 4'd0, 16'd0, 8'd0, 1'b1));
				end
			end
			OP_TEXT: begin
				if (c == CH_NL) begin
					if (!line_over) parse_line();
					line_len = 0;
					line_over = 1'b0;
				end else if (!line_over && line_len + 1 < LINE_LIMIT_D) begin
					line_buf[line_len] = c;
					line_len++;
				end else line_over = 1'b1;
			end
			OP_END: begin
				if (line_len != 0 && !line_over) parse_line();
				line_len = 0;
				line_over = 1'b0;
				cur_vendor = '0;
				vend_known = 1'b0;
			end
			OP_FIND: begin
				ix = lookup(v, d);
				if (ix >= 0)
					answers_due.push_back(mk(KIND_FIND, 1'b1, 4'(ix), 16'd0, 8'd0, 1'b1));
				else answers_due.push_back(mk(KIND_FIND, 1'b0, 4'd0, 16'd0, 8'd0, 1'b1));
			end
			default: ;
		endcase
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
		tbl_count = 0;
		line_len = 0;
		line_over = 1'b0;
		cur_vendor = '0;
		vend_known = 1'b0;
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			// check output first: an answer cannot come in the cycle its item is taken
			if (mon_out.valid && mon_out.ready) begin
				if (answers_due.size() == 0) begin
					$error("unexpected result kind=%0d char=%0h", mon_out.kind, mon_out.name_char);
					fail_count++;
				end else begin
					want = answers_due.pop_front();
					if (mon_out.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, mon_out.kind);
						fail_count++;
					end
					if (mon_out.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, mon_out.ok);
						fail_count++;
					end
					if (mon_out.entry_index !== want.entry_index) begin
						$error("entry_index: expected %0d, got %0d", want.entry_index,
							mon_out.entry_index);
						fail_count++;
					end
					if (mon_out.entry_mask !== want.entry_mask) begin
						$error("entry_mask: expected %h, got %h", want.entry_mask,
							mon_out.entry_mask);
						fail_count++;
					end
					if (mon_out.name_char !== want.name_char) begin
						$error("name_char: expected %h, got %h", want.name_char,
							mon_out.name_char);
						fail_count++;
					end
					if (mon_out.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, mon_out.last);
						fail_count++;
					end
				end
			end
			if (mon_in.valid && mon_in.ready)
				predict(mon_in.op, mon_in.vend_key, mon_in.dev_key, mon_in.text_byte);
			pending = answers_due.size();
		end
	end
endmodule

@@ test/device_id_name_file_matcher_top_test.sv @@
// Stimulus and verdict for the device ID name matcher
`timescale 1ns / 1ps
module device_id_name_file_matcher_top_test;
	import dim_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count;
	int   pending;
	int   send_idle;
	int   recv_idle;
	logic [15:0] vend_pool [4];
	logic [15:0] dev_pool [4];

	dim_in_if  in_ch ();
	dim_out_if out_ch ();

	device_id_name_file_matcher_top i_dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.out_ch(out_ch));
	dim_checker i_check (.clk(clk), .arst_n(arst_n), .mon_in(in_ch), .mon_out(out_ch),
		.fail_count(fail_count), .pending(pending));

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		#50_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// called at a falling edge; returns at the falling edge after the item is taken
	task automatic put_item(logic [2:0] op, logic [15:0] v, logic [15:0] d, logic [7:0] c);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.vend_key <= v;
		in_ch.dev_key <= d;
		in_ch.text_byte <= c;
		// ready only moves at a rising edge, so it is stable here
		while (!in_ch.ready) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++) put_item(OP_TEXT, 16'd0, 16'd0, s[i]);
	endtask

	function automatic string hex16(logic [15:0] v);
		return $sformatf("%04x", v);
	endfunction

	function automatic string rand_name();
		string s = "";
		int n = $urandom_range(3, 1);
		for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(126, 33)))};
		if ($urandom_range(3) == 0) s = {s, " \r"};
		return s;
	endfunction

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// well-formed list text with random content, some noise
	task automatic random_block();
		int r;
		r = $urandom_range(99);
		if (r < 55) begin
			put_text({hex16(vend_pool[$urandom_range(3)]), " ", rand_name(), "\n"});
			repeat ($urandom_range(2, 1))
				put_text({"\t", hex16(dev_pool[$urandom_range(3)]),
					($urandom_range(1) ? " " : "\t"), rand_name(), "\n"});
		end else if (r < 70) begin
			put_item($urandom_range(1) ? OP_ADD : OP_FIND, vend_pool[$urandom_range(3)],
				dev_pool[$urandom_range(3)], 8'($urandom));
		end else if (r < 80) begin
			repeat ($urandom_range(6, 1))
				put_item(OP_TEXT, 16'd0, 16'd0, 8'($urandom_range(255)));
		end else if (r < 85) begin
			put_item(OP_END, 16'($urandom), 16'($urandom), 8'($urandom));
		end else if (r < 88) begin
			put_item(OP_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom));
		end else if (r < 92) begin
			put_item(3'($urandom_range(7, 5)), 16'($urandom), 16'($urandom), 8'($urandom));
		end else if (r < 96) begin
			put_item(OP_ADD, 16'($urandom), 16'($urandom), 8'($urandom));
		end else begin
			put_text({"#", hex16(vend_pool[0]), " x\n\t0000 y ", "\n", "# note\n"});
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.op = OP_CLEAR;
		in_ch.vend_key = '0;
		in_ch.dev_key = '0;
		in_ch.text_byte = '0;
		out_ch.ready = 1'b0;
		send_idle = 22;
		recv_idle = 57;
		for (int i = 0; i < 4; i++) begin
			vend_pool[i] = 16'($urandom);
			dev_pool[i] = 16'($urandom);
		end
		vend_pool[0] = 16'hFFFF;
		dev_pool[0] = 16'h0000;
		vend_pool[1] = 16'h8086;
		dev_pool[1] = 16'hAbCd;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: table extremes, full, duplicate, find hit and miss
		put_item(OP_ADD, 16'hFFFF, 16'h0000, 8'd0);
		put_item(OP_ADD, 16'hFFFF, 16'h0000, 8'd0);
		put_item(OP_FIND, 16'hFFFF, 16'h0000, 8'd0);
		put_item(OP_FIND, 16'h0000, 16'hFFFF, 8'd0);
		put_item(OP_CLEAR, 16'd0, 16'd0, 8'd0);
		for (int i = 0; i < 17; i++) put_item(OP_ADD, 16'h8086, 16'(i), 8'hFF);
		put_item(OP_FIND, 16'h8086, 16'd15, 8'd0);
		put_text("8086 Vendor\r\n\t000F Fifteen\n\t000f\t x\n#8086 c\n");
		put_text("\t\t0001 x\n8086  \n1234 n\n\t0001 n\n");
		put_text({"8086 ", {64{"a"}}, "\n"});
		// a zero byte ends the line text early
		put_text("8086 z");
		put_item(OP_TEXT, 16'd0, 16'd0, CH_NUL);
		put_text("q\n\t0003 t");
		put_item(OP_END, 16'd0, 16'd0, 8'd0);
		put_item(3'd7, 16'hFFFF, 16'hFFFF, 8'hFF);
		put_item(OP_CLEAR, 16'd0, 16'd0, 8'd0);

		// hold off until every answer is back
		drain();

		for (int i = 0; i < 4; i++)
			put_item(OP_ADD, vend_pool[i%4], dev_pool[(i*3)%4], 8'd0);
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = ph == 0 ? 22 : ph == 1 ? 57 : 0;
			recv_idle = ph == 0 ? 57 : ph == 1 ? 22 : 0;
			repeat (3) random_block();
		end
		drain();
		if (fail_count == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule

@@ device_id_name_file_matcher_top.f @@
+incdir+sv
sv/dim_pkg.sv
sv/dim_if.sv
sv/dim_ram.sv
sv/dim_ctrl.sv
sv/dim_dp.sv
sv/device_id_name_file_matcher_top.sv
test/dim_checker.sv
test/device_id_name_file_matcher_top_test.sv
